### src/pca_pkg.sv
// shared types and constants for the palette color adjust and pack block
`timescale 1ns / 1ps

package pca_pkg;

    // field widths
    localparam int COLOR_W = 8;
    localparam int CH_W    = 6;
    localparam int V_W     = 8;
    localparam int D_W     = 9;
    localparam int V100_W  = 15;
    localparam int T_W     = 19;
    localparam int ACC_W   = 29;
    localparam int GAIN_W  = 9;
    localparam int BRI_W   = 8;
    localparam int PIXEL_W = 16;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_ADDR_W = 2;

    // arithmetic constants
    localparam int V_GAIN    = 100;
    localparam int BRI_UNIT  = 6400;
    localparam int BRI_SCALE = 3 * BRI_UNIT;
    localparam int DIVISOR   = 30000;
    localparam int CH_MAX    = 63;
    localparam int Q_LIMIT   = DIVISOR * (CH_MAX + 1);

    // floor(x / DIVISOR) == (x * RECIP) >> RECIP_SHIFT for 0 <= x < 2**QIN_W
    localparam int QIN_W       = 21;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 22;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = QIN_W + RECIP_W;

    // register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SATURATION   = 2'd0,
        REG_CONTRAST     = 2'd1,
        REG_BRIGHTNESS   = 2'd2,
        REG_PIXEL_FORMAT = 2'd3
    } pca_reg_index_t;

    localparam logic FMT_RGB555 = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    localparam logic [GAIN_W-1:0]       SATURATION_RESET = 9'd100;
    localparam logic [GAIN_W-1:0]       CONTRAST_RESET   = 9'd100;
    localparam logic signed [BRI_W-1:0] BRIGHTNESS_RESET = 8'sd0;

    typedef struct packed {
        logic [GAIN_W-1:0]       saturation;
        logic [GAIN_W-1:0]       contrast;
        logic signed [BRI_W-1:0] brightness;
        logic                    pixel_format;
    } pca_cfg_t;

    // pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int ST_DIFF    = 0;
    localparam int ST_SAT     = 1;
    localparam int ST_CON     = 2;
    localparam int ST_DIV     = 3;
    localparam int ST_OUT     = 4;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pca_stage_en_t;

endpackage

### src/palette_color_adjust_pack.sv
// top level of the palette color adjust and pack block
`timescale 1ns / 1ps

// Adjusts one 8-bit RGB color by saturation, contrast and brightness and packs
// it as an RGB555 or RGB565 pixel word. Each channel is cut to 6 bits, the
// adjusted value is divided by 30000 (truncated) and clamped to 0..63. Rate is
// one transfer per clock in and out while the result side does not stall. An
// input transfer loads the first of five register stages (difference,
// saturation multiply, contrast multiply, reciprocal divide and clamp, pack)
// and the item moves one stage on whenever the next stage can take it. The
// output register lets a new input transfer in while a result waits; a stall on
// the result side holds each full stage without loss or repeat. Configuration
// writes take effect on the next clock and are meant for an idle pipeline.

module palette_color_adjust_pack
    import pca_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // color input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COLOR_W-1:0]    s_red_in,
    input  logic [COLOR_W-1:0]    s_green_in,
    input  logic [COLOR_W-1:0]    s_blue_in,

    // pixel output channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIXEL_W-1:0]    m_pixel_word
);

    pca_cfg_t      cfg;
    pca_stage_en_t en;

    logic [CH_W-1:0]    r6;
    logic [CH_W-1:0]    g6;
    logic [CH_W-1:0]    b6;
    logic [V_W-1:0]     v;
    logic [CH_W-1:0]    r_q;
    logic [CH_W-1:0]    g_q;
    logic [CH_W-1:0]    b_q;
    logic [PIXEL_W-1:0] pixel_next;
    logic [PIXEL_W-1:0] pixel_reg;

    pca_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // one valid bit per stage, ready ripples back from the output
    pca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en)
    );

    // reduce to 6 bits and form the luma sum shared by all channels
    always_comb begin
        r6 = s_red_in[COLOR_W-1 -: CH_W];
        g6 = s_green_in[COLOR_W-1 -: CH_W];
        b6 = s_blue_in[COLOR_W-1 -: CH_W];
        v  = V_W'(r6) + V_W'(g6) + V_W'(b6);
    end

    pca_chan u_red (
        .aclk (aclk),
        .c6   (r6),
        .v    (v),
        .cfg  (cfg),
        .en   (en),
        .q6   (r_q)
    );

    pca_chan u_green (
        .aclk (aclk),
        .c6   (g6),
        .v    (v),
        .cfg  (cfg),
        .en   (en),
        .q6   (g_q)
    );

    pca_chan u_blue (
        .aclk (aclk),
        .c6   (b6),
        .v    (v),
        .cfg  (cfg),
        .en   (en),
        .q6   (b_q)
    );

    // pack: 565 keeps all six green bits, 555 drops the low one
    always_comb begin
        if (cfg.pixel_format == FMT_RGB565) begin
            pixel_next = {r_q[CH_W-1:1], g_q, b_q[CH_W-1:1]};
        end else begin
            pixel_next = {1'b0, r_q[CH_W-1:1], g_q[CH_W-1:1], b_q[CH_W-1:1]};
        end
    end

    // output register, holds while the result side stalls
    always_ff @(posedge aclk) begin
        if (en.load[ST_OUT]) begin
            pixel_reg <= pixel_next;
        end
    end

    assign m_pixel_word = pixel_reg;

endmodule

### src/pca_cfg.sv
// configuration register file
`timescale 1ns / 1ps

module pca_cfg
    import pca_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output pca_cfg_t              cfg
);

    pca_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.saturation   <= SATURATION_RESET;
            cfg_reg.contrast     <= CONTRAST_RESET;
            cfg_reg.brightness   <= BRIGHTNESS_RESET;
            cfg_reg.pixel_format <= FMT_RGB565;
        end else if (cfg_wr_en) begin
            unique case (pca_reg_index_t'(cfg_addr))
                REG_SATURATION:   cfg_reg.saturation   <= cfg_wr_data[GAIN_W-1:0];
                REG_CONTRAST:     cfg_reg.contrast     <= cfg_wr_data[GAIN_W-1:0];
                REG_BRIGHTNESS:   cfg_reg.brightness   <= $signed(cfg_wr_data[BRI_W-1:0]);
                REG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_wr_data[0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/pca_ctrl.sv
// valid/ready control for the stage pipeline
`timescale 1ns / 1ps

module pca_ctrl
    import pca_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output pca_stage_en_t en
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   rdy;
    logic [NUM_STAGES:0]   up_valid;

    // a stage takes new data when it is empty or its successor moves
    always_comb begin
        up_valid = {valid_reg, s_valid};
        rdy[NUM_STAGES] = m_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            en.load[i]    = rdy[i] && up_valid[i];
            valid_next[i] = rdy[i] ? up_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

endmodule

### src/pca_chan.sv
// one color channel: gain, contrast, offset, scale and clamp
`timescale 1ns / 1ps

module pca_chan
    import pca_pkg::*;
(
    input  logic            aclk,
    input  logic [CH_W-1:0] c6,
    input  logic [V_W-1:0]  v,
    input  pca_cfg_t        cfg,
    input  pca_stage_en_t   en,
    output logic [CH_W-1:0] q6
);

    localparam logic signed [ACC_W-1:0] BRI_K   = ACC_W'(BRI_SCALE);
    localparam logic signed [ACC_W-1:0] LIMIT_K = ACC_W'(Q_LIMIT);
    localparam logic [V100_W-1:0]       VGAIN_K = V100_W'(V_GAIN);

    logic [V_W-1:0]            c6x3;
    logic signed [D_W-1:0]     d_next;
    logic signed [D_W-1:0]     d_reg;
    logic [V100_W-1:0]         v100_next;
    logic [V100_W-1:0]         v100_reg;
    logic signed [T_W-1:0]     t_next;
    logic signed [T_W-1:0]     t_reg;
    logic signed [ACC_W-1:0]   bri_ext;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [PROD_W-1:0]         prod;
    logic [CH_W-1:0]           q_next;
    logic [CH_W-1:0]           q_reg;

    // stage: chroma difference and luma term
    always_comb begin
        c6x3      = {1'b0, c6, 1'b0} + {2'b00, c6};
        d_next    = $signed({1'b0, c6x3}) - $signed({1'b0, v});
        v100_next = V100_W'(v) * VGAIN_K;
    end

    // stage: saturation gain
    always_comb begin
        t_next = T_W'(d_reg) * $signed({1'b0, cfg.saturation})
               + $signed(T_W'(v100_reg));
    end

    // stage: contrast gain and brightness offset
    always_comb begin
        bri_ext  = ACC_W'(cfg.brightness);
        acc_next = ACC_W'(t_reg) * $signed({1'b0, cfg.contrast}) + bri_ext * BRI_K;
    end

    // stage: divide by reciprocal multiply, clamp to the channel range
    always_comb begin
        prod = PROD_W'(acc_reg[QIN_W-1:0]) * PROD_W'(RECIP);
        if (acc_reg < 0) begin
            q_next = '0;
        end else if (acc_reg >= LIMIT_K) begin
            q_next = CH_W'(CH_MAX);
        end else begin
            q_next = prod[RECIP_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.load[ST_DIFF]) begin
            d_reg    <= d_next;
            v100_reg <= v100_next;
        end
        if (en.load[ST_SAT]) begin
            t_reg <= t_next;
        end
        if (en.load[ST_CON]) begin
            acc_reg <= acc_next;
        end
        if (en.load[ST_DIV]) begin
            q_reg <= q_next;
        end
    end

    assign q6 = q_reg;

endmodule
